FILE: rtl/nfe_pkg.sv
// ----------------------------------------------------------------------------
// Numeric feature encoder package
// Shared types, codes, constants and the square-root table of the exp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nfe_pkg;

   localparam int DEF_MAX_WIDTH = 64;
   localparam int DEF_FRAC_BITS = 16;
   localparam int CFG_W         = 24;
   localparam int CSR_IDX_W     = 4;
   localparam int ELEM_W        = 40;
   localparam int DIV_W         = 64;
   localparam int DIVISOR_W     = 24;
   localparam int MUL_W         = 33;

   localparam logic [32:0] Q32_ONE   = 33'h1_0000_0000;
   localparam logic [32:0] LN2_Q32   = 33'h0_B172_17F8;
   localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7653;

   localparam logic [3:0] OP_RAW       = 4'd0;
   localparam logic [3:0] OP_BINARY    = 4'd1;
   localparam logic [3:0] OP_ONEHOT    = 4'd2;
   localparam logic [3:0] OP_THERMO    = 4'd3;
   localparam logic [3:0] OP_EXPBIN    = 4'd4;
   localparam logic [3:0] OP_TEXPBIN   = 4'd5;
   localparam logic [3:0] OP_LINBIN    = 4'd6;
   localparam logic [3:0] OP_TLINBIN   = 4'd7;
   localparam logic [3:0] OP_EXPNORM   = 4'd8;
   localparam logic [3:0] OP_LINNORM   = 4'd9;

   localparam logic [2:0] POL_EXPLICIT = 3'd0;
   localparam logic [2:0] POL_IMPLICIT = 3'd1;
   localparam logic [2:0] POL_MASKING  = 3'd2;
   localparam logic [2:0] POL_STRICT   = 3'd3;
   localparam logic [2:0] POL_ZERO     = 3'd4;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_NULL     = 2'd1;
   localparam logic [1:0] ERR_UNSUP    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NULL_SENTINEL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASKED_FILL   = 4'd1;

   typedef struct packed {
      logic [3:0]         operation;
      logic [2:0]         null_policy;
      logic signed [23:0] value;
      logic [6:0]         width;
      logic [22:0]        value_max;
      logic [23:0]        slope;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic                     last;
      logic [1:0]               error;
      logic                     clamped;
   } rsp_type;

   typedef struct packed {
      logic                 div_start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
      logic [MUL_W-1:0]     mul_a;
      logic [MUL_W-1:0]     mul_b;
   } unit_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 div_done;
      logic [DIV_W-1:0]     quotient;
      logic [2*MUL_W-1:0]   product;
   } unit_rsp_type;

   typedef logic [31:0][31:0] root_tbl_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = x;
      res = '0;
      bt  = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (bt > rem) begin
            bt = bt >> 2;
         end
      end
      for (int j = 0; j < 32; j++) begin
         if (bt != '0) begin
            if (rem >= res + bt) begin
               rem = rem - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
            bt = bt >> 2;
         end
      end
      return res;
   endfunction

   // Entry j holds 2^-(2^-(j+1)) in Q32, the repeated square roots of one half.
   function automatic root_tbl_type build_root_tbl();
      root_tbl_type t;
      logic [63:0]  c;
      c = 64'h8000_0000;
      for (int j = 0; j < 32; j++) begin
         c    = isqrt64(c << 32);
         t[j] = c[31:0];
      end
      return t;
   endfunction

   localparam root_tbl_type ROOT_TBL = build_root_tbl();

endpackage

`default_nettype wire

FILE: rtl/nfe_unit.sv
// ----------------------------------------------------------------------------
// Numeric feature encoder arithmetic unit
// Shared multiplier and a restoring divider that retires one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nfe_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  nfe_pkg::unit_req_type unit_req,
   output nfe_pkg::unit_rsp_type unit_rsp
);
   import nfe_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (unit_req.div_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = unit_req.divisor;
         quo_in  = unit_req.dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign unit_rsp.busy     = busy_ff;
   assign unit_rsp.div_done = done_ff;
   assign unit_rsp.quotient = quo_ff;
   assign unit_rsp.product  = (2*MUL_W)'(unit_req.mul_a) * (2*MUL_W)'(unit_req.mul_b);

endmodule

`default_nettype wire

FILE: rtl/numeric_feature_encoder.sv
// ----------------------------------------------------------------------------
// Numeric feature encoder
// Encodes one integer per request into a run of signed fixed-point feature
// elements: raw, binary, one-hot, thermometer, bin codes and norms.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Contents
//   req_     in         valid / stall      one value with kind, policy, width
//   rsp_     out        valid / stall      one element with last, error, flag
//   csr_     in         valid / ready      register index and write data
//
// With no curve needed, an item is set up and then emits one element per cycle
// while the result channel does not stall. Linear bins and norms add one divide.
// Log bins and log norms run two divides, 32 exp steps, up to 32 normalize steps
// and 32 squaring steps on the shared unit before the first element.
// Reset returns the sequencer to idle and both registers to all ones.
// A stalled result holds in the output register while the run waits.
//
`default_nettype none

module numeric_feature_encoder #(
   parameter int MAX_WIDTH = nfe_pkg::DEF_MAX_WIDTH,
   parameter int FRAC_BITS = nfe_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  nfe_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output nfe_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nfe_pkg::CFG_W-1:0]     csr_wdata
);
   import nfe_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_PREP   = 16'h0002,
      S_RDIV   = 16'h0004,
      S_TMUL   = 16'h0008,
      S_EXP    = 16'h0010,
      S_ESHIFT = 16'h0020,
      S_QMUL   = 16'h0040,
      S_NORM   = 16'h0080,
      S_SQ     = 16'h0100,
      S_LNHI   = 16'h0200,
      S_LNLO   = 16'h0400,
      S_DDIV   = 16'h0800,
      S_IDXMUL = 16'h1000,
      S_LDIV   = 16'h2000,
      S_SETUP  = 16'h4000,
      S_EMIT   = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      BM_CONST,
      BM_BIN,
      BM_THERMO,
      BM_ONEHOT
   } body_type;

   localparam logic [ELEM_W-1:0] ONE_ELEM = ELEM_W'(1) << FRAC_BITS;
   localparam logic [33:0]       RND_HALF = 34'(1) << (31 - FRAC_BITS);

   function automatic logic [ELEM_W-1:0] int_elem(input logic [23:0] x);
      return ELEM_W'({{16{x[23]}}, x} << FRAC_BITS);
   endfunction

   state_type          state_ff, state_in;
   logic [23:0]        sentinel_ff, sentinel_in;
   logic [23:0]        fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [3:0]         op_ff, op_in;
   logic [2:0]         pol_ff, pol_in;
   logic [23:0]        v_ff, v_in;
   logic [6:0]         n_ff, n_in;
   logic [22:0]        vmax_ff, vmax_in;
   logic [23:0]        s16_ff, s16_in;
   logic [1:0]         err_ff, err_in;
   logic               clamped_ff, clamped_in;
   logic               null_ff, null_in;

   logic [32:0]        r_ff, r_in;
   logic [8:0]         ti_ff, ti_in;
   logic [31:0]        f_ff, f_in;
   logic [32:0]        acc_ff, acc_in;
   logic [32:0]        e_ff, e_in;
   logic [4:0]         step_ff, step_in;
   logic [33:0]        m_ff, m_in;
   logic [6:0]         k_ff, k_in;
   logic [31:0]        frac_ff, frac_in;
   logic [39:0]        lnv_ff, lnv_in;
   logic [32:0]        curve_ff, curve_in;
   logic [ELEM_W-1:0]  nv_ff, nv_in;
   logic [39:0]        idx_ff, idx_in;

   logic               flag_ff, flag_in;
   body_type           bmode_ff, bmode_in;
   logic [6:0]         blen_ff, blen_in;
   logic [6:0]         total_ff, total_in;
   logic [ELEM_W-1:0]  cst_ff, cst_in;
   logic [6:0]         ones_ff, ones_in;
   logic [23:0]        pos_ff, pos_in;
   logic [6:0]         eidx_ff, eidx_in;

   unit_req_type       unit_req;
   unit_rsp_type       unit_rsp;

   logic               req_acc;
   logic [6:0]         n_norm;
   logic [22:0]        vmax_norm;
   logic [23:0]        s_norm;
   logic               is_raw;
   logic               unsup;
   logic               over;
   logic [23:0]        v_clamp;
   logic               vpos;
   logic [6:0]         inner;
   logic               need_curve;
   logic               need_lin;
   logic [38:0]        l_val;
   logic [39:0]        lnv_total;
   logic [33:0]        q_sum;
   logic [34:0]        sq;
   logic [32:0]        curve_new;
   logic [33:0]        rnd_sum;
   logic [24:0]        v_inc;
   logic [40:0]        idx_inc;
   logic [6:0]         bi;
   logic               is_flag;
   logic [ELEM_W-1:0]  body_elem;
   logic [ELEM_W-1:0]  cur_elem;
   logic               out_free;

   nfe_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_data.width == 7'd0) begin
         n_norm = 7'd1;
      end else if (req_data.width > 7'(MAX_WIDTH)) begin
         n_norm = 7'(MAX_WIDTH);
      end else begin
         n_norm = req_data.width;
      end
      vmax_norm = (req_data.value_max == '0) ? 23'd1 : req_data.value_max;
      s_norm    = (req_data.slope == '0) ? 24'd1 : req_data.slope;
      is_raw    = (req_data.operation == OP_RAW);
      unsup     = (req_data.operation > OP_LINNORM) || (req_data.null_policy > POL_ZERO) ||
                  ((req_data.null_policy == POL_IMPLICIT) &&
                   ((req_data.operation == OP_BINARY) || (req_data.operation == OP_EXPNORM) ||
                    (req_data.operation == OP_LINNORM)));
      over      = !req_data.value[23] && (req_data.value[22:0] > vmax_norm);
      v_clamp   = (!is_raw && !unsup && over) ? {1'b0, vmax_norm} : req_data.value;
   end

   always_comb begin
      vpos       = !v_ff[23] && (v_ff != '0);
      inner      = (pol_ff == POL_EXPLICIT) ? n_ff - 7'd1 : n_ff;
      need_curve = (err_ff == ERR_OK) && vpos &&
                   ((op_ff == OP_EXPBIN) || (op_ff == OP_TEXPBIN) || (op_ff == OP_EXPNORM));
      need_lin   = (err_ff == ERR_OK) && vpos &&
                   ((op_ff == OP_LINBIN) || (op_ff == OP_TLINBIN) || (op_ff == OP_LINNORM));
      l_val      = {k_ff, 32'd0} - 39'(frac_ff);
      lnv_total  = lnv_ff + 40'(unit_rsp.product[63:32]);
      q_sum      = 34'(r_ff) + 34'(unit_rsp.product[65:32]);
      sq         = unit_rsp.product[65:31];
      curve_new  = (unit_rsp.quotient[63:32] == '0) ?
                   (Q32_ONE - 33'(unit_rsp.quotient[31:0])) : '0;
      rnd_sum    = 34'(curve_new) + RND_HALF;
      v_inc      = 25'(v_ff[22:0]) + 25'd1;
      idx_inc    = 41'(idx_ff) + 41'd1;
   end

   always_comb begin
      unit_req = '0;
      unique case (state_ff)
         S_PREP: begin
            unit_req.div_start = need_curve || need_lin;
            if (need_curve) begin
               unit_req.dividend = 64'(v_ff[22:0]) << 32;
               unit_req.divisor  = 24'(vmax_ff);
            end else if (op_ff == OP_LINNORM) begin
               unit_req.dividend = 64'(v_ff[22:0]) << (FRAC_BITS + 1);
               unit_req.divisor  = 24'(vmax_ff);
            end else begin
               unit_req.dividend = 64'(v_ff[22:0]) << 16;
               unit_req.divisor  = s16_ff;
            end
         end
         S_TMUL: begin
            unit_req.mul_a = 33'(s16_ff);
            unit_req.mul_b = LOG2E_Q32;
         end
         S_EXP: begin
            unit_req.mul_a = acc_ff;
            unit_req.mul_b = 33'(ROOT_TBL[step_ff]);
         end
         S_QMUL: begin
            unit_req.mul_a = Q32_ONE - r_ff;
            unit_req.mul_b = e_ff;
         end
         S_SQ: begin
            unit_req.mul_a = m_ff[32:0];
            unit_req.mul_b = m_ff[32:0];
         end
         S_LNHI: begin
            unit_req.mul_a = 33'(l_val[38:32]);
            unit_req.mul_b = LN2_Q32;
         end
         S_LNLO: begin
            unit_req.mul_a     = 33'(l_val[31:0]);
            unit_req.mul_b     = LN2_Q32;
            unit_req.div_start = 1'b1;
            unit_req.dividend  = 64'(lnv_total) << 16;
            unit_req.divisor   = s16_ff;
         end
         S_IDXMUL: begin
            unit_req.mul_a = curve_ff;
            unit_req.mul_b = 33'(inner);
         end
         default: begin
            unit_req = '0;
         end
      endcase
   end

   always_comb begin
      is_flag = flag_ff && (eidx_ff == 7'd0);
      bi      = eidx_ff - 7'(flag_ff);
      case (bmode_ff)
         BM_CONST:  body_elem = cst_ff;
         BM_BIN:    body_elem = (vpos && (bi < 7'd24) && v_ff[bi[4:0]]) ? ONE_ELEM : '0;
         BM_THERMO: body_elem = (bi < ones_ff) ? ONE_ELEM : '0;
         default:   body_elem = (24'(bi) == pos_ff) ? ONE_ELEM : '0;
      endcase
      cur_elem = is_flag ? (null_ff ? ONE_ELEM : '0) : body_elem;
   end

   always_comb begin
      state_in     = state_ff;
      sentinel_in  = sentinel_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      pol_in       = pol_ff;
      v_in         = v_ff;
      n_in         = n_ff;
      vmax_in      = vmax_ff;
      s16_in       = s16_ff;
      err_in       = err_ff;
      clamped_in   = clamped_ff;
      null_in      = null_ff;
      r_in         = r_ff;
      ti_in        = ti_ff;
      f_in         = f_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      step_in      = step_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      lnv_in       = lnv_ff;
      curve_in     = curve_ff;
      nv_in        = nv_ff;
      idx_in       = idx_ff;
      flag_in      = flag_ff;
      bmode_in     = bmode_ff;
      blen_in      = blen_ff;
      total_in     = total_ff;
      cst_in       = cst_ff;
      ones_in      = ones_ff;
      pos_in       = pos_ff;
      eidx_in      = eidx_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NULL_SENTINEL: sentinel_in = csr_wdata;
            CSR_MASKED_FILL:   fill_in     = csr_wdata;
            default:           sentinel_in = sentinel_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in      = req_data.operation;
               pol_in     = req_data.null_policy;
               v_in       = v_clamp;
               n_in       = n_norm;
               vmax_in    = vmax_norm;
               s16_in     = s_norm;
               clamped_in = !is_raw && !unsup && over;
               null_in    = (v_clamp == sentinel_ff);
               if (is_raw) begin
                  err_in = ERR_OK;
               end else if (unsup) begin
                  err_in = ERR_UNSUP;
               end else if ((req_data.null_policy == POL_STRICT) &&
                            (v_clamp == sentinel_ff)) begin
                  err_in = ERR_NULL;
               end else begin
                  err_in = ERR_OK;
               end
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            nv_in  = '0;
            idx_in = '0;
            if (need_curve) begin
               state_in = S_RDIV;
            end else if (need_lin) begin
               state_in = S_LDIV;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_RDIV: begin
            if (unit_rsp.div_done) begin
               r_in     = unit_rsp.quotient[32:0];
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            ti_in    = unit_rsp.product[56:48];
            f_in     = unit_rsp.product[47:16];
            acc_in   = Q32_ONE;
            step_in  = '0;
            state_in = S_EXP;
         end
         S_EXP: begin
            if (f_ff[31]) begin
               acc_in = unit_rsp.product[64:32];
            end
            f_in    = {f_ff[30:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = S_ESHIFT;
            end
         end
         S_ESHIFT: begin
            e_in     = (ti_ff < 9'd64) ? (acc_ff >> ti_ff[5:0]) : '0;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            m_in    = q_sum;
            frac_in = '0;
            if (q_sum == '0) begin
               k_in     = 7'd64;
               state_in = S_LNHI;
            end else begin
               k_in     = '0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (m_ff[33:32] == 2'd0) begin
               m_in = {m_ff[32:0], 1'b0};
               k_in = k_ff + 7'd1;
            end else begin
               m_in     = {1'b0, m_ff[33:1]};
               step_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (sq[34:32] != 3'd0) begin
               m_in    = 34'(sq >> 1);
               frac_in = {frac_ff[30:0], 1'b1};
            end else begin
               m_in    = 34'(sq);
               frac_in = {frac_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = S_LNHI;
            end
         end
         S_LNHI: begin
            lnv_in   = unit_rsp.product[39:0];
            state_in = S_LNLO;
         end
         S_LNLO: begin
            state_in = S_DDIV;
         end
         S_DDIV: begin
            if (unit_rsp.div_done) begin
               curve_in = curve_new;
               if (op_ff == OP_EXPNORM) begin
                  nv_in    = ELEM_W'(rnd_sum >> (32 - FRAC_BITS));
                  state_in = S_SETUP;
               end else begin
                  state_in = S_IDXMUL;
               end
            end
         end
         S_IDXMUL: begin
            idx_in   = 40'(unit_rsp.product[65:32]);
            state_in = S_SETUP;
         end
         S_LDIV: begin
            if (unit_rsp.div_done) begin
               if (op_ff == OP_LINNORM) begin
                  nv_in = ELEM_W'((unit_rsp.quotient + 64'd1) >> 1);
               end else begin
                  idx_in = unit_rsp.quotient[39:0];
               end
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            flag_in  = 1'b0;
            blen_in  = 7'd1;
            bmode_in = BM_CONST;
            cst_in   = '0;
            ones_in  = '0;
            pos_in   = '0;
            if (op_ff == OP_RAW) begin
               cst_in = int_elem(v_ff);
            end else if (err_ff != ERR_OK) begin
               cst_in = '0;
            end else if (op_ff >= OP_EXPNORM) begin
               flag_in = (pol_ff == POL_EXPLICIT);
               cst_in  = ((pol_ff == POL_MASKING) && null_ff) ? int_elem(fill_ff) : nv_ff;
            end else if ((pol_ff == POL_MASKING) && null_ff) begin
               blen_in = n_ff;
               cst_in  = int_elem(fill_ff);
            end else if ((pol_ff == POL_IMPLICIT) && null_ff) begin
               blen_in = n_ff;
            end else if ((pol_ff == POL_EXPLICIT) && (op_ff != OP_BINARY) && null_ff) begin
               flag_in = 1'b1;
               blen_in = n_ff - 7'd1;
            end else begin
               flag_in = (pol_ff == POL_EXPLICIT);
               blen_in = inner;
               case (op_ff)
                  OP_BINARY: begin
                     bmode_in = BM_BIN;
                  end
                  OP_THERMO: begin
                     bmode_in = BM_THERMO;
                     if (!v_ff[23]) begin
                        ones_in = (v_inc > 25'(inner)) ? inner : 7'(v_inc);
                     end else if (pol_ff == POL_ZERO) begin
                        ones_in = (inner == '0) ? 7'd0 : 7'd1;
                     end else begin
                        ones_in = '0;
                     end
                  end
                  OP_TEXPBIN, OP_TLINBIN: begin
                     bmode_in = BM_THERMO;
                     ones_in  = (idx_inc > 41'(inner)) ? inner : 7'(idx_inc);
                  end
                  OP_ONEHOT: begin
                     bmode_in = BM_ONEHOT;
                     pos_in   = vpos ? v_ff : '0;
                  end
                  default: begin
                     bmode_in = BM_ONEHOT;
                     if ((inner != '0) && (idx_ff > 40'(inner - 7'd1))) begin
                        pos_in = 24'(inner - 7'd1);
                     end else begin
                        pos_in = idx_ff[23:0];
                     end
                  end
               endcase
            end
            total_in = 7'(flag_in) + blen_in;
            eidx_in  = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.element = cur_elem;
               rsp_in.last    = (eidx_ff == total_ff - 7'd1);
               rsp_in.error   = err_ff;
               rsp_in.clamped = clamped_ff;
               eidx_in        = eidx_ff + 7'd1;
               if (eidx_ff == total_ff - 7'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sentinel_ff  <= '1;
         fill_ff      <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sentinel_ff  <= sentinel_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      op_ff      <= op_in;
      pol_ff     <= pol_in;
      v_ff       <= v_in;
      n_ff       <= n_in;
      vmax_ff    <= vmax_in;
      s16_ff     <= s16_in;
      err_ff     <= err_in;
      clamped_ff <= clamped_in;
      null_ff    <= null_in;
      r_ff       <= r_in;
      ti_ff      <= ti_in;
      f_ff       <= f_in;
      acc_ff     <= acc_in;
      e_ff       <= e_in;
      step_ff    <= step_in;
      m_ff       <= m_in;
      k_ff       <= k_in;
      frac_ff    <= frac_in;
      lnv_ff     <= lnv_in;
      curve_ff   <= curve_in;
      nv_ff      <= nv_in;
      idx_ff     <= idx_in;
      flag_ff    <= flag_in;
      bmode_ff   <= bmode_in;
      blen_ff    <= blen_in;
      total_ff   <= total_in;
      cst_ff     <= cst_in;
      ones_ff    <= ones_in;
      pos_ff     <= pos_in;
      eidx_ff    <= eidx_in;
   end

   // An error transfer is always a single zero element.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.error != ERR_OK)) |-> (rsp_data.last && (rsp_data.element == '0)))
      else $error("error result is not a single zero element");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> ((eidx_ff < total_ff) && (blen_ff <= total_ff)))
      else $error("element counter ran past the run length");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !unit_rsp.busy)
      else $error("divider still busy while the sequencer is idle");

endmodule

`default_nettype wire

FILE: tb/tb_nfe_checker.sv
// ----------------------------------------------------------------------------
// Numeric feature encoder checker
// Watches the request, result and register channels, predicts the element run
// for every accepted request and compares each result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nfe_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  nfe_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  nfe_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [nfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nfe_pkg::CFG_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending,
   output int                            checked
);
   import nfe_pkg::*;

   localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

   logic signed [23:0] sentinel;
   logic signed [23:0] fill;
   rsp_type            expected_elems[$];

   function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bt;
      res = 0;
      bt  = 64'h1 << 62;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x   = x - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] pow2_neg(input logic [63:0] f);
      logic [63:0] acc;
      logic [63:0] c;
      acc = ONE_Q32;
      c   = 64'h8000_0000;
      for (int i = 1; i <= 32; i++) begin
         c = sqrt_floor(c << 32);
         if (f[32-i]) acc = (acc * c) >> 32;
      end
      return acc;
   endfunction

   function automatic logic [63:0] minus_log2(input logic [63:0] q);
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] k;
      if (q == 0) return 64'd64 << 32;
      m    = q;
      frac = 0;
      k    = 0;
      while (m < ONE_Q32) begin
         m = m << 1;
         k++;
      end
      m = m >> 1;
      for (int i = 1; i <= 32; i++) begin
         m = (m * m) >> 31;
         if (m >= ONE_Q32) begin
            m    = m >> 1;
            frac = frac | (64'h1 << (32 - i));
         end
      end
      return (k << 32) - frac;
   endfunction

   function automatic logic [63:0] log_curve(input logic [63:0] v, input logic [63:0] vmax,
                                             input logic [63:0] s);
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] q;
      logic [63:0] l;
      logic [63:0] lnv;
      logic [63:0] d;
      r = (v << 32) / vmax;
      t = (s * 64'(LOG2E_Q32)) >> 16;
      e = pow2_neg({32'h0, t[31:0]});
      e = ((t >> 32) < 64) ? (e >> (t >> 32)) : 0;
      q = r + (((ONE_Q32 - r) * e) >> 32);
      l = minus_log2(q);
      lnv = (l >> 32) * 64'(LN2_Q32) + ((64'(l[31:0]) * 64'(LN2_Q32)) >> 32);
      d = (lnv << 16) / s;
      return (d < ONE_Q32) ? (ONE_Q32 - d) : 0;
   endfunction

   function automatic logic [39:0] fixed_int(input longint k);
      return 40'(k <<< 16);
   endfunction

   task automatic predict_run(input req_type rq);
      logic [39:0] run[$];
      logic [1:0]  err;
      logic        clamped;
      logic        isnull;
      logic        thermo;
      longint      v;
      logic [63:0] n;
      logic [63:0] vmax;
      logic [63:0] s;
      logic [63:0] nv;
      logic [63:0] inner;
      logic [63:0] idx;
      logic [63:0] ones;
      logic [63:0] bit_val;
      longint      pos;
      rsp_type     r;
      err     = ERR_OK;
      clamped = 1'b0;
      v       = longint'(rq.value);
      n       = (rq.width == 0) ? 1 : ((rq.width > 64) ? 64 : 64'(rq.width));
      vmax    = (rq.value_max == 0) ? 1 : 64'(rq.value_max);
      s       = (rq.slope == 0) ? 1 : 64'(rq.slope);
      if (rq.operation == OP_RAW) begin
         run.insert(run.size(), fixed_int(v));
      end else if (rq.operation > OP_LINNORM || rq.null_policy > POL_ZERO ||
                   (rq.null_policy == POL_IMPLICIT && (rq.operation == OP_BINARY ||
                    rq.operation == OP_EXPNORM || rq.operation == OP_LINNORM))) begin
         err = ERR_UNSUP;
         run.insert(run.size(), 40'd0);
      end else begin
         if (v > longint'(vmax)) begin
            v       = longint'(vmax);
            clamped = 1'b1;
         end
         isnull = (v == longint'(sentinel));
         if (rq.null_policy == POL_STRICT && isnull) begin
            err = ERR_NULL;
            run.insert(run.size(), 40'd0);
         end else if (rq.operation >= OP_EXPNORM) begin
            nv = 0;
            if (v > 0) begin
               if (rq.operation == OP_EXPNORM)
                  nv = (log_curve(v, vmax, s) + 64'h8000) >> 16;
               else
                  nv = (((64'(v) << 17) / vmax) + 1) >> 1;
            end
            if (rq.null_policy == POL_EXPLICIT) run.insert(run.size(), fixed_int(isnull));
            if (rq.null_policy == POL_MASKING && isnull) run.insert(run.size(), fixed_int(fill));
            else run.insert(run.size(), nv[39:0]);
         end else if (rq.null_policy == POL_MASKING && isnull) begin
            for (int i = 0; i < n; i++) run.insert(run.size(), fixed_int(fill));
         end else if (rq.null_policy == POL_IMPLICIT && isnull) begin
            for (int i = 0; i < n; i++) run.insert(run.size(), 40'd0);
         end else if (rq.null_policy == POL_EXPLICIT && rq.operation != OP_BINARY && isnull) begin
            run.insert(run.size(), fixed_int(1));
            for (int i = 1; i < n; i++) run.insert(run.size(), 40'd0);
         end else begin
            inner  = n;
            pos    = -1;
            ones   = 0;
            idx    = 0;
            thermo = (rq.operation == OP_THERMO || rq.operation == OP_TEXPBIN ||
                      rq.operation == OP_TLINBIN);
            if (rq.null_policy == POL_EXPLICIT) begin
               run.insert(run.size(), fixed_int(isnull));
               inner = n - 1;
            end
            if (rq.operation == OP_EXPBIN || rq.operation == OP_TEXPBIN) begin
               if (v > 0) idx = (log_curve(v, vmax, s) * inner) >> 32;
            end else if (rq.operation == OP_LINBIN || rq.operation == OP_TLINBIN) begin
               if (v > 0) idx = (64'(v) << 16) / s;
            end
            if (rq.operation == OP_ONEHOT)
               pos = (v <= 0) ? 0 : v;
            else if (rq.operation == OP_EXPBIN || rq.operation == OP_LINBIN)
               pos = (inner > 0 && idx > inner - 1) ? longint'(inner - 1) : longint'(idx);
            else if (rq.operation == OP_THERMO)
               ones = (v >= 0) ? 64'(v + 1) : ((rq.null_policy == POL_ZERO) ? 1 : 0);
            else if (thermo)
               ones = idx + 1;
            if (ones > inner) ones = inner;
            for (longint i = 0; i < longint'(inner); i++) begin
               if (rq.operation == OP_BINARY)
                  bit_val = (v > 0) ? ((64'(v) >> i) & 1) : 0;
               else if (thermo)
                  bit_val = (i < longint'(ones)) ? 1 : 0;
               else
                  bit_val = (i == pos) ? 1 : 0;
               run.insert(run.size(), fixed_int(longint'(bit_val)));
            end
         end
      end
      foreach (run[k]) begin
         r.element = run[k];
         r.last    = (k == run.size() - 1);
         r.error   = err;
         r.clamped = clamped;
         expected_elems.insert(expected_elems.size(), r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sentinel <= -24'sd1;
         fill     <= -24'sd1;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NULL_SENTINEL) sentinel <= csr_wdata;
            else if (csr_index == CSR_MASKED_FILL) fill <= csr_wdata;
         end
         if (req_valid && !req_stall) predict_run(req_data);
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_elems.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected result transfer: %p", rsp_data);
            end else begin
               want = expected_elems.pop_front();
               if (rsp_data.element !== want.element || rsp_data.last !== want.last ||
                   rsp_data.error !== want.error || rsp_data.clamped !== want.clamped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("Mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
      pending <= expected_elems.size();
   end

   initial begin
      fail_count = 0;
      checked    = 0;
      pending    = 0;
   end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Numeric feature encoder testbench
// Drives directed and random requests under several register settings, with
// random gaps and result stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import nfe_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   pending;
   int                   checked;
   int                   cycles = 0;
   int                   sent = 0;
   logic                 steady = 1'b0;
   logic signed [23:0]   cur_sentinel = -24'sd1;

   numeric_feature_encoder dut (.*);

   tb_nfe_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   task automatic send(input req_type rq);
      logic ok;
      while (!steady && ($urandom_range(99) < 34)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] wd);
      logic ok;
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wd;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      if (idx == CSR_NULL_SENTINEL) cur_sentinel = wd;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic req_type item(input logic [3:0] op, input logic [2:0] pol,
                                    input int v, input int w, input int vmax, input int s);
      req_type rq;
      rq.operation   = op;
      rq.null_policy = pol;
      rq.value       = 24'(v);
      rq.width       = 7'(w);
      rq.value_max   = 23'(vmax);
      rq.slope       = 24'(s);
      return rq;
   endfunction

   function automatic req_type random_item();
      req_type rq;
      rq = '0;
      rq.operation   = 4'(($urandom_range(99) < 4) ? $urandom_range(15) : $urandom_range(9));
      rq.null_policy = 3'(($urandom_range(99) < 4) ? $urandom_range(7) : $urandom_range(4));
      rq.width       = 7'(($urandom_range(99) < 10) ? $urandom_range(127) :
                          $urandom_range(1, 16));
      case ($urandom_range(3))
         0: rq.value_max = 23'($urandom_range(1, 100));
         1: rq.value_max = 23'($urandom_range(0, 4000));
         2: rq.value_max = 23'($urandom);
         default: rq.value_max = 23'($urandom_range(1, 20));
      endcase
      case ($urandom_range(5))
         0: rq.value = cur_sentinel;
         1: rq.value = 24'(int'($urandom_range(0, 40)) - 8);
         2: rq.value = 24'(rq.value_max);
         3: rq.value = 24'(rq.value_max) + 24'($urandom_range(1, 5));
         4: rq.value = 24'($urandom_range(0, rq.value_max));
         default: rq.value = 24'($urandom);
      endcase
      case ($urandom_range(3))
         0: rq.slope = 24'($urandom_range(0, 20));
         1: rq.slope = 24'($urandom_range(1, 8) << 16);
         2: rq.slope = 24'($urandom_range(1, 1 << 20));
         default: rq.slope = 24'($urandom);
      endcase
      return rq;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(item(OP_RAW, POL_EXPLICIT, -8388608, 4, 10, 65536));
      send(item(OP_RAW, 3'd7, 8388607, 4, 10, 65536));
      send(item(OP_BINARY, POL_ZERO, 8388607, 64, 8388607, 65536));
      send(item(OP_BINARY, POL_EXPLICIT, -1, 8, 100, 65536));
      send(item(OP_BINARY, POL_IMPLICIT, 5, 8, 100, 65536));
      send(item(OP_ONEHOT, POL_ZERO, 3, 8, 100, 65536));
      send(item(OP_ONEHOT, POL_ZERO, 50, 8, 100, 65536));
      send(item(OP_ONEHOT, POL_IMPLICIT, -1, 0, 100, 65536));
      send(item(OP_THERMO, POL_ZERO, -5, 8, 100, 65536));
      send(item(OP_THERMO, POL_EXPLICIT, 30, 8, 20, 65536));
      send(item(OP_THERMO, POL_MASKING, -1, 127, 20, 65536));
      send(item(OP_EXPBIN, POL_ZERO, 7, 10, 10, 3 << 16));
      send(item(OP_TEXPBIN, POL_EXPLICIT, 10, 10, 10, 16777215));
      send(item(OP_LINBIN, POL_ZERO, 100, 8, 200, 0));
      send(item(OP_TLINBIN, POL_ZERO, 9, 16, 200, 2 << 16));
      send(item(OP_EXPNORM, POL_EXPLICIT, 5, 4, 0, 1));
      send(item(OP_EXPNORM, POL_ZERO, 1, 4, 8388607, 65536));
      send(item(OP_LINNORM, POL_MASKING, -1, 4, 3, 65536));
      send(item(OP_LINNORM, POL_ZERO, 2, 4, 3, 65536));
      send(item(OP_LINNORM, POL_IMPLICIT, 2, 4, 3, 65536));
      send(item(OP_ONEHOT, POL_STRICT, -1, 4, 3, 65536));
      send(item(4'd12, POL_ZERO, 2, 4, 3, 65536));
      send(item(OP_ONEHOT, 3'd5, 2, 4, 3, 65536));
      send(item(OP_ONEHOT, POL_EXPLICIT, 2, 1, 3, 65536));
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_reg(CSR_NULL_SENTINEL, 24'd5); write_reg(CSR_MASKED_FILL, 24'd0); end
            1: begin
               write_reg(CSR_NULL_SENTINEL, 24'h800000);
               write_reg(CSR_MASKED_FILL, 24'h7FFFFF);
            end
            2: begin
               write_reg(CSR_NULL_SENTINEL, 24'h7FFFFF);
               write_reg(CSR_MASKED_FILL, 24'h800000);
            end
            3: begin
               write_reg(CSR_NULL_SENTINEL, 24'd0);
               write_reg(CSR_MASKED_FILL, CFG_W'($urandom));
            end
            default: begin
               write_reg(CSR_NULL_SENTINEL, CFG_W'($urandom_range(1, 30)));
               write_reg(CSR_MASKED_FILL, CFG_W'($urandom));
            end
         endcase
         steady = (phase == 2);
         for (int i = 0; i < 100; i++) send(random_item());
         steady = 1'b0;
         drain();
      end

      $display("Sent %0d requests over six register settings, checked %0d elements.",
               sent, checked);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("Failures: %0d", fail_count);
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
